// ----- rtl/pctd_pkg.sv -----
// Shared types, codes and default sizes for the prefix code table decoder.
`timescale 1ns / 1ps

package pctd_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 256;
   localparam int MAX_CODE_LEN_DEFAULT  = 32;

   // Item operation codes.
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_BIT  = 2'd1;
   localparam logic [1:0] OP_EOL  = 2'd2;

   // Result kind codes.
   localparam logic [1:0] KIND_SYMBOL   = 2'd0;
   localparam logic [1:0] KIND_LINE_END = 2'd1;
   localparam logic [1:0] KIND_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  entry_index;
      logic [7:0]  entry_symbol;
      logic [31:0] entry_code;
      logic [5:0]  entry_length;
      logic        code_bit;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] symbol;
      logic [5:0] leftover_bits;
   } rsp_type;

   // One code table entry as stored in the table memory.
   typedef struct packed {
      logic [7:0]  symbol;
      logic [31:0] code;
      logic [5:0]  length;
   } entry_type;

   // Result handed from the sequencer to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// ----- rtl/prefix_code_table_decoder_top.sv -----
// Top level of the prefix code table decoder: handshakes, table writes and output register.
`timescale 1ns / 1ps

// A load transaction writes one table entry and an end of line transaction
// passes its marker through the result state and the output register. A code
// bit transaction scans the code table through the single read port of the
// table memory, one entry per cycle in index order, and stops at the first
// match; no new transaction is accepted until the scan ends and any symbol or
// overflow it yields has been taken into the output register. Results wait in
// an output register so that a stalled result channel holds back further
// transactions only while that register is full and a new result waits. Per-entry
// valid bits make the table empty right after reset; no clearing pass is needed.
module prefix_code_table_decoder_top #(
   parameter int TABLE_ENTRIES = pctd_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int MAX_CODE_LEN  = pctd_pkg::MAX_CODE_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pctd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pctd_pkg::rsp_type rsp_data
);
   import pctd_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic             busy;
   logic             req_acc;
   logic             wr_en;
   entry_type        wr_entry;
   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   entry_type        rd_entry;
   result_type       result;
   logic             result_take;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   assign req_stall = busy;
   assign req_acc   = req_valid && !busy;

   // Loads to a slot past the table size are dropped.
   assign wr_en = req_acc && (req_data.op == OP_LOAD)
      && ({1'b0, req_data.entry_index} < 9'(TABLE_ENTRIES));
   assign wr_entry.symbol = req_data.entry_symbol;
   assign wr_entry.code   = req_data.entry_code;
   assign wr_entry.length = req_data.entry_length;

   pctd_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_idx  (req_data.entry_index[IDX_W-1:0]),
      .wr_entry(wr_entry),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_entry(rd_entry)
   );

   pctd_seq #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_acc),
      .item       (req_data),
      .busy       (busy),
      .rd_en      (rd_en),
      .rd_idx     (rd_idx),
      .rd_entry   (rd_entry),
      .result     (result),
      .result_take(result_take)
   );

   assign result_take = result.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (result_take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/pctd_table.sv -----
// Code table memory with one write port, one registered read port and per-entry valid bits.
`timescale 1ns / 1ps

module pctd_table #(
   parameter int TABLE_ENTRIES = pctd_pkg::TABLE_ENTRIES_DEFAULT,
   localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_idx,
   input  pctd_pkg::entry_type wr_entry,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_idx,
   output pctd_pkg::entry_type rd_entry
);
   import pctd_pkg::*;

   entry_type                mem [TABLE_ENTRIES];
   entry_type                rd_data_ff;
   logic                     rd_valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   // An entry never loaded since reset reads as empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_idx];
         end
      end
   end

   always_comb begin
      rd_entry = rd_data_ff;
      if (!rd_valid_ff) begin
         rd_entry.length = '0;
      end
   end

endmodule

// ----- rtl/pctd_seq.sv -----
// Sequencer: pending code buffer, table scan and result formation.
`timescale 1ns / 1ps

module pctd_seq #(
   parameter int TABLE_ENTRIES = pctd_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int MAX_CODE_LEN  = pctd_pkg::MAX_CODE_LEN_DEFAULT,
   localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  pctd_pkg::req_type    item,
   output logic                 busy,
   output logic                 rd_en,
   output logic [IDX_W-1:0]     rd_idx,
   input  pctd_pkg::entry_type  rd_entry,
   output pctd_pkg::result_type result,
   input  logic                 result_take
);
   import pctd_pkg::*;

   localparam int W     = MAX_CODE_LEN;
   localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_CODE_LEN);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   state_type         state_ff, state_in;
   logic [W-1:0]      pend_ff, pend_in;
   logic [W-1:0]      mask_ff, mask_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  addr_ff, addr_in;
   logic              issue_done_ff, issue_done_in;
   logic              chk_ff, chk_in;
   logic              chk_last_ff, chk_last_in;
   rsp_type           res_ff, res_in;
   logic [W:0]        shifted;
   logic [W-1:0]      code_ext;
   logic              hit;

   assign busy   = (state_ff != ST_IDLE);
   assign rd_en  = (state_ff == ST_SCAN) && !issue_done_ff;
   assign rd_idx = addr_ff;

   assign result.valid = (state_ff == ST_RESULT);
   assign result.data  = res_ff;

   assign shifted  = {pend_ff, item.code_bit};
   assign code_ext = W'(rd_entry.code);

   // The buffer holds only cnt_ff bits, so an equal length plus equal masked
   // code means an exact match; length zero can never equal a nonzero count.
   assign hit = chk_ff
      && (CMP_W'(rd_entry.length) == CMP_W'(cnt_ff))
      && (((code_ext ^ pend_ff) & mask_ff) == '0);

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      mask_in       = mask_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      issue_done_in = issue_done_ff;
      chk_in        = 1'b0;
      chk_last_in   = 1'b0;
      res_in        = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && (item.op == OP_BIT)) begin
               pend_in       = shifted[W-1:0];
               cnt_in        = cnt_ff + CNT_W'(1);
               mask_in       = ~({W{1'b1}} << (cnt_ff + CNT_W'(1)));
               addr_in       = '0;
               issue_done_in = 1'b0;
               state_in      = ST_SCAN;
            end else if (item_valid && (item.op == OP_EOL)) begin
               res_in.kind          = KIND_LINE_END;
               res_in.symbol        = '0;
               res_in.leftover_bits = 6'(cnt_ff);
               pend_in              = '0;
               cnt_in               = '0;
               state_in             = ST_RESULT;
            end
         end
         ST_SCAN: begin
            if (!issue_done_ff) begin
               chk_in      = 1'b1;
               chk_last_in = (addr_ff == LAST_IDX);
               if (addr_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  addr_in = addr_ff + IDX_W'(1);
               end
            end
            if (hit) begin
               res_in.kind          = KIND_SYMBOL;
               res_in.symbol        = rd_entry.symbol;
               res_in.leftover_bits = '0;
               pend_in              = '0;
               cnt_in               = '0;
               chk_in               = 1'b0;
               state_in             = ST_RESULT;
            end else if (chk_ff && chk_last_ff) begin
               if (cnt_ff == MAX_CNT) begin
                  res_in.kind          = KIND_OVERFLOW;
                  res_in.symbol        = '0;
                  res_in.leftover_bits = 6'(cnt_ff);
                  pend_in              = '0;
                  cnt_in               = '0;
                  state_in             = ST_RESULT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RESULT: begin
            if (result_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= '0;
         cnt_ff        <= '0;
         issue_done_ff <= 1'b0;
         chk_ff        <= 1'b0;
         chk_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         cnt_ff        <= cnt_in;
         issue_done_ff <= issue_done_in;
         chk_ff        <= chk_in;
         chk_last_ff   <= chk_last_in;
      end
      mask_ff <= mask_in;
      addr_ff <= addr_in;
      res_ff  <= res_in;
   end

endmodule

// ----- dv/pctd_tb_pkg.sv -----
// Scoreboard class that predicts and checks the prefix code table decoder results.
`timescale 1ns / 1ps

package pctd_tb_pkg;
   import pctd_pkg::*;

   localparam int NUM_ENTRIES = TABLE_ENTRIES_DEFAULT;
   localparam int MAX_LEN     = MAX_CODE_LEN_DEFAULT;

   class decode_tracker_type;
      logic [7:0]  slot_symbol [NUM_ENTRIES];
      logic [31:0] slot_code   [NUM_ENTRIES];
      logic [5:0]  slot_length [NUM_ENTRIES];
      logic [31:0] buffer_bits;
      int          buffer_count;
      rsp_type     due_results [$];
      int          mismatches;
      int          symbols_seen;
      int          line_ends_seen;
      int          overflows_seen;

      function new();
         foreach (slot_length[i]) begin
            slot_symbol[i] = '0;
            slot_code[i]   = '0;
            slot_length[i] = '0;
         end
         buffer_bits  = '0;
         buffer_count = 0;
      endfunction

      // Applies one accepted transaction to the table and buffer copy and queues any result.
      function void decode_item(req_type item);
         rsp_type outcome;
         bit      matched;
         outcome = '0;
         matched = 1'b0;
         case (item.op)
            OP_LOAD: begin
               if (item.entry_index < NUM_ENTRIES) begin
                  slot_symbol[item.entry_index] = item.entry_symbol;
                  slot_code[item.entry_index]   = item.entry_code;
                  slot_length[item.entry_index] = item.entry_length;
               end
            end
            OP_EOL: begin
               outcome.kind          = KIND_LINE_END;
               outcome.leftover_bits = 6'(buffer_count);
               due_results  = {due_results, outcome};
               buffer_bits  = '0;
               buffer_count = 0;
            end
            OP_BIT: begin
               buffer_bits = {buffer_bits[30:0], item.code_bit};
               buffer_count++;
               // Slots are scanned in index order, so the lowest matching slot wins.
               for (int i = 0; i < NUM_ENTRIES && !matched; i++) begin
                  if (slot_length[i] != 0 && slot_length[i] <= MAX_LEN &&
                      slot_length[i] == buffer_count &&
                      (slot_code[i] & (32'hFFFF_FFFF >> (32 - slot_length[i]))) == buffer_bits)
                  begin
                     outcome.kind   = KIND_SYMBOL;
                     outcome.symbol = slot_symbol[i];
                     matched        = 1'b1;
                  end
               end
               if (matched) begin
                  due_results  = {due_results, outcome};
                  buffer_bits  = '0;
                  buffer_count = 0;
               end else if (buffer_count >= MAX_LEN) begin
                  outcome.kind          = KIND_OVERFLOW;
                  outcome.leftover_bits = 6'(buffer_count);
                  due_results  = {due_results, outcome};
                  buffer_bits  = '0;
                  buffer_count = 0;
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void match_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("unexpected result: kind %0d symbol %0d leftover_bits %0d",
                   got.kind, got.symbol, got.leftover_bits);
            mismatches++;
            return;
         end
         want = due_results.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            mismatches++;
         end
         if (got.symbol !== want.symbol) begin
            $error("symbol: expected %0d, actual %0d", want.symbol, got.symbol);
            mismatches++;
         end
         if (got.leftover_bits !== want.leftover_bits) begin
            $error("leftover_bits: expected %0d, actual %0d",
                   want.leftover_bits, got.leftover_bits);
            mismatches++;
         end
         case (want.kind)
            KIND_SYMBOL:   symbols_seen++;
            KIND_LINE_END: line_ends_seen++;
            default:       overflows_seen++;
         endcase
      endfunction
   endclass

endpackage

// ----- dv/tb_top.sv -----
// Testbench top for the prefix code table decoder: directed items, then random code tables and streams.
`timescale 1ns / 1ps

module tb_top;
   import pctd_pkg::*;
   import pctd_tb_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         ITEM_TARGET  = 1500;
   localparam int         DRAIN_CYCLES = 300;

   typedef enum int {STYLE_FULL, STYLE_SPARSE, STYLE_CHAIN} table_style_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   decode_tracker_type tracker = new();
   bit                 req_busy;
   bit                 rsp_busy;
   int                 items_sent;
   int                 slot_order [NUM_ENTRIES];
   int                 live_slots [$];

   prefix_code_table_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int draw_wait(bit busy);
      return busy ? int'($urandom_range(0, 19)) : 0;
   endfunction

   // Unused fields of every transaction carry random bits.
   function automatic req_type random_item(input logic [1:0] op);
      logic [63:0] noise;
      req_type     item;
      noise   = {$urandom, $urandom};
      item    = noise[$bits(req_type)-1:0];
      item.op = op;
      return item;
   endfunction

   // Valid stays high from one transaction to the next when no gap is drawn.
   task automatic send_item(input req_type item);
      int gap;
      gap = draw_wait(req_busy);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.decode_item(item);
      if (item.op != OP_UNUSED) items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.due_results.size() != 0);
   endtask

   task automatic load_entry(input int slot, input logic [7:0] sym, input logic [31:0] code,
                             input logic [5:0] len);
      req_type item;
      item              = random_item(OP_LOAD);
      item.entry_index  = 8'(slot);
      item.entry_symbol = sym;
      item.entry_code   = code;
      item.entry_length = len;
      send_item(item);
      if (len != 0) live_slots = {live_slots, slot};
   endtask

   task automatic send_bit(input logic value);
      req_type item;
      item          = random_item(OP_BIT);
      item.code_bit = value;
      send_item(item);
   endtask

   // Sends the first nbits of a codeword, most significant used bit first.
   task automatic send_prefix(input logic [31:0] code, input int len, input int nbits);
      for (int k = len - 1; k >= len - nbits; k--) send_bit(code[k]);
   endtask

   task automatic run_round(input table_style_type shape);
      logic [31:0] leaf_code [$];
      int          leaf_len  [$];
      logic [31:0] lost_code [$];
      int          lost_len  [$];
      int          stale     [$];
      int          target, pick, r, used, k, n, tmp, depth;
      logic [31:0] base;
      logic        flip;

      drain_results();
      req_busy = ($urandom_range(0, 3) != 0);
      rsp_busy = ($urandom_range(0, 3) != 0);

      // Empty everything the previous round loaded so stale codes cannot shadow new ones.
      stale = live_slots;
      live_slots.delete();
      foreach (stale[s]) load_entry(stale[s], 8'($urandom), $urandom, 6'd0);

      for (int i = NUM_ENTRIES - 1; i > 0; i--) begin
         k             = $urandom_range(0, i);
         tmp           = slot_order[i];
         slot_order[i] = slot_order[k];
         slot_order[k] = tmp;
      end

      // Grow a prefix-free code by splitting leaves; the chain shape reaches MAX_LEN.
      leaf_code = {leaf_code, 32'h0};
      leaf_len  = {leaf_len, 0};
      target = (shape == STYLE_CHAIN) ? MAX_LEN + 1 : int'($urandom_range(2, 16));
      while (leaf_code.size() < target) begin
         pick = (shape == STYLE_CHAIN) ? leaf_code.size() - 1
                                       : int'($urandom_range(0, leaf_code.size() - 1));
         if (leaf_len[pick] < MAX_LEN) begin
            base            = leaf_code[pick] << 1;
            depth           = leaf_len[pick] + 1;
            flip            = 1'($urandom);
            leaf_code[pick] = base | 32'(flip);
            leaf_len[pick]  = depth;
            leaf_code       = {leaf_code, base | 32'(!flip)};
            leaf_len        = {leaf_len, depth};
         end
      end

      // Dropped leaves leave holes in the code; their paths run into overflow.
      if (shape != STYLE_FULL) begin
         n = (shape == STYLE_CHAIN) ? 1 : 1 + int'($urandom_range(0, leaf_code.size() / 4));
         repeat (n) begin
            pick = $urandom_range(0, leaf_code.size() - ((shape == STYLE_CHAIN) ? 3 : 1));
            lost_code = {lost_code, leaf_code[pick]};
            lost_len  = {lost_len, leaf_len[pick]};
            leaf_code.delete(pick);
            leaf_len.delete(pick);
         end
      end

      used = 0;
      foreach (leaf_code[i]) begin
         load_entry(slot_order[used], 8'($urandom), leaf_code[i] | ($urandom << leaf_len[i]),
                    6'(leaf_len[i]));
         used++;
      end
      repeat ($urandom_range(0, 3)) begin
         load_entry(slot_order[used], 8'($urandom), $urandom,
                    6'($urandom_range(MAX_LEN + 1, 63)));
         used++;
      end
      if ($urandom_range(0, 1) != 0) begin
         pick = $urandom_range(0, leaf_code.size() - 1);
         load_entry(slot_order[used], 8'($urandom), leaf_code[pick], 6'(leaf_len[pick]));
         used++;
      end

      repeat ($urandom_range(15, 40)) begin
         r    = $urandom_range(0, 99);
         pick = $urandom_range(0, leaf_code.size() - 1);
         if (shape == STYLE_CHAIN && r < 20) pick = leaf_code.size() - 1;
         if (r < 70) begin
            send_prefix(leaf_code[pick], leaf_len[pick], leaf_len[pick]);
         end else if (r < 76) begin
            send_prefix(leaf_code[pick], leaf_len[pick],
                        int'($urandom_range(0, leaf_len[pick] - 1)));
            send_item(random_item(OP_EOL));
         end else if (r < 82) begin
            send_item(random_item(OP_EOL));
         end else if (r < 92 && lost_code.size() != 0) begin
            k = $urandom_range(0, lost_code.size() - 1);
            send_prefix(lost_code[k], lost_len[k], lost_len[k]);
            repeat (MAX_LEN - lost_len[k]) send_bit(1'($urandom));
         end else if (r < 92) begin
            repeat ($urandom_range(1, 40)) send_bit(1'($urandom));
         end else if (r < 95) begin
            send_item(random_item(OP_UNUSED));
         end else begin
            load_entry(slot_order[used], 8'($urandom), $urandom,
                       ($urandom_range(0, 1) != 0) ? 6'($urandom_range(MAX_LEN + 1, 63)) : 6'd0);
            used++;
         end
      end
      send_item(random_item(OP_EOL));
   endtask

   initial begin : result_sink
      int hold;
      rsp_stall = 1'b0;
      hold      = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            tracker.match_result(rsp_data);
            hold = draw_wait(rsp_busy);
         end else if (rsp_valid === 1'b1 && hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold != 0);
      end
   end

   initial begin : stimulus
      table_style_type shape;
      int              rounds;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      req_busy  = 1'b1;
      rsp_busy  = 1'b1;
      rounds    = 0;
      foreach (slot_order[i]) slot_order[i] = i;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // A line end on an empty buffer still produces a marker.
      send_item(random_item(OP_EOL));
      send_item(random_item(OP_UNUSED));
      // Slots 0 and 255 hold the same one-bit code; the lower slot must win.
      load_entry(0, 8'hA5, 32'hFFFF_FFFE, 6'd1);
      load_entry(255, 8'h00, 32'h0000_0000, 6'd1);
      load_entry(1, 8'hFF, 32'h0000_0001, 6'd0);
      // Lengths above the maximum are stored but never match.
      load_entry(2, 8'h5A, 32'hFFFF_FFFF, 6'd33);
      load_entry(4, 8'h81, 32'hFFFF_FFFF, 6'd63);
      load_entry(3, 8'h3C, 32'h5555_5557, 6'd2);
      send_bit(1'b0);
      send_bit(1'b1);
      send_bit(1'b1);
      send_bit(1'b1);
      send_item(random_item(OP_EOL));
      send_bit(1'b1);
      send_bit(1'b0);
      send_item(random_item(OP_EOL));
      load_entry(0, 8'h7E, 32'h0000_0000, 6'd0);
      send_bit(1'b0);

      while (items_sent < ITEM_TARGET) begin
         shape = (rounds == 0) ? STYLE_CHAIN : table_style_type'($urandom_range(0, 2));
         run_round(shape);
         rounds++;
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions across %0d code tables.", items_sent, rounds);
      $display("Checked %0d symbols, %0d line ends and %0d overflows.",
               tracker.symbols_seen, tracker.line_ends_seen, tracker.overflows_seen);
      if (tracker.mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #60ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/pctd_pkg.sv
rtl/pctd_table.sv
rtl/pctd_seq.sv
rtl/prefix_code_table_decoder_top.sv
dv/pctd_tb_pkg.sv
dv/tb_top.sv
